[rtl/scfp_pkg.sv]
`timescale 1ns / 1ps
// Package for the sync/command/length frame parser: phase codes, result kinds and constants.
package scfp_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h88;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_CMD      = 3'd1,
        PH_LEN      = 3'd2,
        PH_DATA     = 3'd3,
        PH_CHECKSUM = 3'd4
    } phase_t;

    typedef enum logic {
        KIND_PAYLOAD   = 1'b0,
        KIND_FRAME_END = 1'b1
    } result_kind_t;

endpackage

[rtl/scfp_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received bytes and parser results.
interface scfp_rx_if;
    logic                 valid;
    logic                 ready;
    scfp_pkg::byte_t      rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfp_res_if;
    logic                 valid;
    logic                 ready;
    logic                 result_kind;
    scfp_pkg::byte_t      payload_byte;
    scfp_pkg::byte_t      byte_index;
    scfp_pkg::byte_t      frame_cmd;
    scfp_pkg::byte_t      frame_len;
    logic                 checksum_ok;

    modport source (
        output valid, output result_kind, output payload_byte, output byte_index,
        output frame_cmd, output frame_len, output checksum_ok, input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input byte_index,
        input frame_cmd, input frame_len, input checksum_ok, output ready
    );
endinterface

[rtl/sync_cmd_len_frame_parser.sv]
`timescale 1ns / 1ps
// Frame parser top level: sync, command, length, payload, checksum.
//
// rx carries one received byte per word. res carries one result per word:
// a payload result (byte, index, command, length) for each payload byte, and
// a frame-end result (command, length, checksum_ok) for the checksum byte.
// Sync, command and length bytes, and bytes dropped while hunting, give no word.
// cfg_wr_en/cfg_wr_data write the sync byte value; write it only while idle.
//
// Throughput: one byte per cycle while rx.ready is high. A result is in the
// output register in the cycle after its byte is accepted. The parser state
// and the output register are the only stages; rx.ready is high whenever the
// output register is empty or is being taken in the same cycle, so a stalled
// receiver holds the result and stalls rx after one word.
//
// Reset: the parser hunts for sync, held command, length, count and sum are
// zero, the sync byte returns to 0x88 and the output register is empty.
module sync_cmd_len_frame_parser (
    input  logic              clk,
    input  logic              rst_n,
    scfp_rx_if.sink           rx,
    scfp_res_if.source        res,
    input  logic              cfg_wr_en,
    input  scfp_pkg::byte_t   cfg_wr_data
);

    scfp_pkg::phase_t phase_reg, phase_next;
    scfp_pkg::byte_t  sync_reg;
    scfp_pkg::byte_t  cmd_reg, cmd_next;
    scfp_pkg::byte_t  len_reg, len_next;
    scfp_pkg::byte_t  count_reg, count_next;
    scfp_pkg::byte_t  sum_reg, sum_next;

    logic             out_valid_reg, out_valid_next;
    logic             kind_reg, kind_next;
    scfp_pkg::byte_t  pbyte_reg, pbyte_next;
    scfp_pkg::byte_t  index_reg, index_next;
    scfp_pkg::byte_t  fcmd_reg, fcmd_next;
    scfp_pkg::byte_t  flen_reg, flen_next;
    logic             ok_reg, ok_next;

    logic             accept;
    logic             produce;
    scfp_pkg::byte_t  count_inc;

    assign rx.ready  = !out_valid_reg || res.ready;
    assign accept    = rx.valid && rx.ready;
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        produce    = 1'b0;
        kind_next  = scfp_pkg::KIND_PAYLOAD;
        pbyte_next = '0;
        index_next = '0;
        fcmd_next  = cmd_reg;
        flen_next  = len_reg;
        ok_next    = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                scfp_pkg::PH_CMD:
                begin
                    cmd_next   = rx.rx_byte;
                    sum_next   = sum_reg + rx.rx_byte;
                    phase_next = scfp_pkg::PH_LEN;
                end
                scfp_pkg::PH_LEN:
                begin
                    len_next   = rx.rx_byte;
                    sum_next   = sum_reg + rx.rx_byte;
                    count_next = '0;
                    phase_next = (rx.rx_byte == 8'd0) ? scfp_pkg::PH_CHECKSUM
                                                      : scfp_pkg::PH_DATA;
                end
                scfp_pkg::PH_DATA:
                begin
                    produce    = 1'b1;
                    kind_next  = scfp_pkg::KIND_PAYLOAD;
                    pbyte_next = rx.rx_byte;
                    index_next = count_reg;
                    sum_next   = sum_reg + rx.rx_byte;
                    count_next = count_inc;
                    if (count_inc == len_reg)
                    begin
                        phase_next = scfp_pkg::PH_CHECKSUM;
                    end
                end
                scfp_pkg::PH_CHECKSUM:
                begin
                    produce    = 1'b1;
                    kind_next  = scfp_pkg::KIND_FRAME_END;
                    ok_next    = (rx.rx_byte == sum_reg);
                    phase_next = scfp_pkg::PH_IDLE;
                end
                default:
                begin
                    if (rx.rx_byte == sync_reg)
                    begin
                        sum_next   = rx.rx_byte;
                        phase_next = scfp_pkg::PH_CMD;
                    end
                    else
                    begin
                        phase_next = scfp_pkg::PH_IDLE;
                    end
                end
            endcase
        end

        if (accept && produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= scfp_pkg::PH_IDLE;
            sync_reg      <= scfp_pkg::SYNC_RESET;
            cmd_reg       <= '0;
            len_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cmd_reg       <= cmd_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                sync_reg <= cfg_wr_data;
            end
        end
    end

    // Load the result word only when a byte produces one.
    always_ff @(posedge clk)
    begin
        if (accept && produce)
        begin
            kind_reg  <= kind_next;
            pbyte_reg <= pbyte_next;
            index_reg <= index_next;
            fcmd_reg  <= fcmd_next;
            flen_reg  <= flen_next;
            ok_reg    <= ok_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.result_kind  = kind_reg;
    assign res.payload_byte = pbyte_reg;
    assign res.byte_index   = index_reg;
    assign res.frame_cmd    = fcmd_reg;
    assign res.frame_len    = flen_reg;
    assign res.checksum_ok  = ok_reg;

endmodule

[dv/sync_cmd_len_frame_parser_tb.sv]
`timescale 1ns / 1ps
// Testbench for the frame parser: random framed byte streams, scoreboard prediction, stall checks.
module sync_cmd_len_frame_parser_tb;

    localparam int unsigned CLK_HALF     = 5;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_BYTES  = 250;
    localparam int unsigned MAX_GAP      = 13;

    typedef struct {
        scfp_pkg::result_kind_t kind;
        scfp_pkg::byte_t        payload;
        scfp_pkg::byte_t        index;
        scfp_pkg::byte_t        cmd;
        scfp_pkg::byte_t        len;
        logic                   ok;
    } frame_word_t;

    class frame_scoreboard;
        scfp_pkg::byte_t  sync_val;
        scfp_pkg::phase_t ph;
        scfp_pkg::byte_t  cmd;
        scfp_pkg::byte_t  len;
        scfp_pkg::byte_t  count;
        scfp_pkg::byte_t  sum;
        frame_word_t      expected_q[$];
        int unsigned      errors;
        int unsigned      taken;

        function new();
            sync_val = scfp_pkg::SYNC_RESET;
            ph       = scfp_pkg::PH_IDLE;
            cmd      = '0;
            len      = '0;
            count    = '0;
            sum      = '0;
            errors   = 0;
            taken    = 0;
        endfunction

        function void set_sync(scfp_pkg::byte_t v);
            sync_val = v;
        endfunction

        function void note_byte(scfp_pkg::byte_t b);
            frame_word_t w;
            case (ph)
                scfp_pkg::PH_CMD: begin
                    cmd = b;
                    sum = sum + b;
                    ph  = scfp_pkg::PH_LEN;
                    taken++;
                end
                scfp_pkg::PH_LEN: begin
                    len   = b;
                    sum   = sum + b;
                    count = '0;
                    ph    = (b == 8'd0) ? scfp_pkg::PH_CHECKSUM : scfp_pkg::PH_DATA;
                    taken++;
                end
                scfp_pkg::PH_DATA: begin
                    w.kind    = scfp_pkg::KIND_PAYLOAD;
                    w.payload = b;
                    w.index   = count;
                    w.cmd     = cmd;
                    w.len     = len;
                    w.ok      = 1'b0;
                    expected_q.push_back(w);
                    sum   = sum + b;
                    count = count + 8'd1;
                    if (count == len)
                        ph = scfp_pkg::PH_CHECKSUM;
                    taken++;
                end
                scfp_pkg::PH_CHECKSUM: begin
                    w.kind    = scfp_pkg::KIND_FRAME_END;
                    w.payload = '0;
                    w.index   = '0;
                    w.cmd     = cmd;
                    w.len     = len;
                    w.ok      = (b == sum);
                    expected_q.push_back(w);
                    ph = scfp_pkg::PH_IDLE;
                    taken++;
                end
                default: begin
                    if (b == sync_val) begin
                        sum = b;
                        ph  = scfp_pkg::PH_CMD;
                        taken++;
                    end else begin
                        ph = scfp_pkg::PH_IDLE;
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_word(frame_word_t got);
            frame_word_t w;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: expected none, actual kind %0d byte %0d index %0d",
                         $time, got.kind, got.payload, got.index);
                return;
            end
            w = expected_q.pop_front();
            compare_field("result_kind", w.kind, got.kind);
            compare_field("payload_byte", w.payload, got.payload);
            compare_field("byte_index", w.index, got.index);
            compare_field("frame_cmd", w.cmd, got.cmd);
            compare_field("frame_len", w.len, got.len);
            compare_field("checksum_ok", w.ok, got.ok);
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            cfg_wr_en;
    scfp_pkg::byte_t cfg_wr_data;
    bit              src_idle;
    bit              snk_idle;
    bit              hold_req;
    int unsigned     cycles;
    frame_scoreboard sb;

    scfp_rx_if  rx_ch ();
    scfp_res_if res_ch ();

    sync_cmd_len_frame_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx_ch),
        .res         (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        frame_word_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.kind    = scfp_pkg::result_kind_t'(res_ch.result_kind);
            got.payload = res_ch.payload_byte;
            got.index   = res_ch.byte_index;
            got.cmd     = res_ch.frame_cmd;
            got.len     = res_ch.frame_len;
            got.ok      = res_ch.checksum_ok;
            sb.check_word(got);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned gap;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req     = 1'b0;
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = snk_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0)
            begin
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    task automatic send_byte(input scfp_pkg::byte_t b);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            rx_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid   = 1'b1;
        rx_ch.rx_byte = b;
        do @(posedge clk); while (!rx_ch.ready);
        sb.note_byte(b);
        @(negedge clk);
    endtask

    // keep < len truncates the frame: no checksum is sent
    task automatic send_frame(input scfp_pkg::byte_t cmd, input int unsigned len,
                              input bit good, input int unsigned keep);
        scfp_pkg::byte_t sum;
        scfp_pkg::byte_t p;
        sum = sb.sync_val + cmd + scfp_pkg::byte_t'(len);
        send_byte(sb.sync_val);
        send_byte(cmd);
        send_byte(scfp_pkg::byte_t'(len));
        for (int unsigned i = 0; i < len && i < keep; i++)
        begin
            p   = scfp_pkg::byte_t'($urandom_range(0, 255));
            sum = sum + p;
            send_byte(p);
        end
        if (keep >= len)
            send_byte(good ? sum : sum + scfp_pkg::byte_t'($urandom_range(1, 255)));
    endtask

    task automatic drain();
        rx_ch.valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_sync(input scfp_pkg::byte_t v);
        while (sb.ph != scfp_pkg::PH_IDLE)
            send_byte(scfp_pkg::byte_t'($urandom_range(0, 255)));
        drain();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        sb.set_sync(v);
    endtask

    task automatic random_traffic(input int unsigned upto);
        int unsigned r;
        int unsigned len;
        while (sb.taken < upto)
        begin
            r   = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
            if ($urandom_range(0, 29) == 0)
            begin
                src_idle = ($urandom_range(0, 3) != 0);
                snk_idle = ($urandom_range(0, 3) != 0);
            end
            if (r < 78)
                send_frame(($urandom_range(0, 7) == 0)
                               ? sb.sync_val
                               : scfp_pkg::byte_t'($urandom_range(0, 255)),
                           len, ($urandom_range(0, 9) < 7), len);
            else if (r < 90)
                send_byte(scfp_pkg::byte_t'($urandom_range(0, 255)));
            else
                send_frame(scfp_pkg::byte_t'($urandom_range(0, 255)), len + 1, 1'b1,
                           $urandom_range(0, len));
        end
    endtask

    initial
    begin
        sb          = new();
        cycles      = 0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        src_idle    = 1'b1;
        snk_idle    = 1'b1;
        hold_req    = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'h00, 0, 1'b1, 0);
        send_frame(8'hFF, 2, 1'b0, 2);
        send_frame(scfp_pkg::SYNC_RESET, 1, 1'b1, 1);
        send_frame(8'h5A, 3, 1'b1, 1);
        drain();

        // long receiver hold-off while the sender keeps pushing
        hold_req = 1'b1;
        src_idle = 1'b0;
        send_frame(8'h3C, 40, 1'b1, 40);
        src_idle = 1'b1;
        random_traffic(PHASE_BYTES);

        write_sync(8'h00);
        send_frame(8'hC3, 255, 1'b1, 255);
        drain();
        random_traffic(2 * PHASE_BYTES);

        write_sync(8'hFF);
        random_traffic(3 * PHASE_BYTES);

        write_sync(scfp_pkg::byte_t'($urandom_range(1, 254)));
        random_traffic(4 * PHASE_BYTES);

        write_sync(scfp_pkg::SYNC_RESET);
        src_idle = 1'b0;
        snk_idle = 1'b0;
        random_traffic(4 * PHASE_BYTES + PHASE_BYTES / 2);
        src_idle = 1'b1;
        snk_idle = 1'b1;
        random_traffic(5 * PHASE_BYTES);

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
rtl/scfp_pkg.sv
rtl/scfp_if.sv
rtl/sync_cmd_len_frame_parser.sv
dv/sync_cmd_len_frame_parser_tb.sv
